/* hdl/laes_pkg.sv */
// Package for the latency aware endpoint selector: shared types, codes and constants.
// Used by laes_div, laes_ctrl, laes_dp and the top level.
package laes_pkg;

    localparam int DIV_W = 40;
    localparam logic [DIV_W-1:0] SCORE_SCALE = 40'd1000000;
    localparam logic [22:0] TOTAL_MAX = 23'h7FFFFF;

    localparam logic [2:0]  RST_ENDPOINT_COUNT = 3'd3;
    localparam logic [1:0]  RST_PICK_MODE      = 2'd1;
    localparam logic [31:0] RST_WARMUP         = 32'd10000;
    localparam logic [10:0] RST_OVERLOAD       = 11'd100;
    localparam logic [10:0] RST_POOL_CAP       = 11'd512;
    localparam logic [15:0] RST_RESCORE        = 16'd100;

    localparam logic [2:0] REG_ENDPOINT_COUNT = 3'd0;
    localparam logic [2:0] REG_PICK_MODE      = 3'd1;
    localparam logic [2:0] REG_WARMUP         = 3'd2;
    localparam logic [2:0] REG_OVERLOAD       = 3'd3;
    localparam logic [2:0] REG_POOL_CAP       = 3'd4;
    localparam logic [2:0] REG_RESCORE        = 3'd5;

    localparam logic [1:0] REQ_PICK    = 2'd0;
    localparam logic [1:0] REQ_COMPL   = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;

    localparam logic [1:0] MODE_LEAST    = 2'd0;
    localparam logic [1:0] MODE_LATENCY  = 2'd1;
    localparam logic [1:0] MODE_WEIGHTED = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_LL, S_LL_END, S_ML_DIV, S_ML_WAIT, S_ML_END, S_OVL,
        S_PER_WAIT, S_RS_AVG, S_RS_AVGW, S_RS_SC, S_RS_SCW, S_RS_TOT,
        S_PTR, S_PTR_WAIT, S_WALK, S_POOL, S_DONE
    } t_state;

    typedef enum logic [1:0] {DIV_AVG, DIV_SCORE, DIV_PTR, DIV_PER} t_div_op;
    typedef enum logic [1:0] {ADDR_SCAN, ADDR_IDX, ADDR_CHOSEN} t_addr_sel;

    typedef struct packed {
        logic      capture;
        t_addr_sel addr_sel;
        logic      scan_clr;
        logic      ll_step;
        logic      lat_step;
        logic      div_start;
        t_div_op   div_op;
        logic      save_avg;
        logic      score_wr;
        logic      total_wr;
        logic      pcnt_inc;
        logic      walk_init;
        logic      ptr_load;
        logic      walk_step;
        logic      take_best;
        logic      set_fell;
        logic      pool;
        logic      compl;
        logic      release_conn;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] mode;
        logic       cc0_lt_warm;
        logic       overloaded;
        logic       scan_last;
        logic       div_done;
        logic       rem_zero;
        logic       walk_hit;
        logic       total_zero;
    } t_dp_sts;

endpackage

/* hdl/laes_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on laes_pkg for DIV_W.
module laes_div import laes_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quot,
    output logic [DIV_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_dvs;
    logic [DIV_W:0]   w_trial;
    logic [DIV_W:0]   w_diff;

    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[DIV_W]) begin
                r_rem <= w_diff[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

/* hdl/laes_ctrl.sv */
// Sequencing state machine of the endpoint selector.
// Depends on laes_pkg; drives laes_dp through t_dp_cmd and reads t_dp_sts.
module laes_ctrl import laes_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output logic    o_done,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_sts.req_type != REQ_PICK) begin
                    n_state = S_DONE;
                end else if (i_sts.mode == MODE_WEIGHTED) begin
                    n_state = S_PER_WAIT;
                end else if (i_sts.mode == MODE_LATENCY && !i_sts.cc0_lt_warm) begin
                    n_state = S_ML_DIV;
                end else begin
                    n_state = S_LL;
                end
            end
            S_LL: begin
                if (i_sts.scan_last) n_state = S_LL_END;
            end
            S_LL_END:  n_state = S_POOL;
            S_ML_DIV:  n_state = S_ML_WAIT;
            S_ML_WAIT: begin
                if (i_sts.div_done) n_state = i_sts.scan_last ? S_ML_END : S_ML_DIV;
            end
            S_ML_END: n_state = S_OVL;
            S_OVL:    n_state = i_sts.overloaded ? S_LL : S_POOL;
            S_PER_WAIT: begin
                if (i_sts.div_done) n_state = i_sts.rem_zero ? S_RS_AVG : S_PTR;
            end
            S_RS_AVG:  n_state = S_RS_AVGW;
            S_RS_AVGW: begin
                if (i_sts.div_done) n_state = S_RS_SC;
            end
            S_RS_SC:   n_state = S_RS_SCW;
            S_RS_SCW: begin
                if (i_sts.div_done) n_state = i_sts.scan_last ? S_RS_TOT : S_RS_AVG;
            end
            S_RS_TOT: n_state = S_PTR;
            S_PTR:    n_state = i_sts.total_zero ? S_WALK : S_PTR_WAIT;
            S_PTR_WAIT: begin
                if (i_sts.div_done) n_state = S_WALK;
            end
            S_WALK: begin
                if (i_sts.walk_hit || i_sts.scan_last) n_state = S_OVL;
            end
            S_POOL:  n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.addr_sel = ADDR_SCAN;
        o_cmd.div_op   = DIV_AVG;
        busy           = (r_state != S_IDLE);
        o_done         = (r_state == S_DONE);
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = start;
            end
            S_DECODE: begin
                o_cmd.addr_sel = ADDR_IDX;
                if (i_sts.req_type == REQ_COMPL) begin
                    o_cmd.compl = 1'b1;
                end else if (i_sts.req_type == REQ_RELEASE) begin
                    o_cmd.release_conn = 1'b1;
                end else if (i_sts.req_type == REQ_PICK) begin
                    if (i_sts.mode == MODE_WEIGHTED) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_op    = DIV_PER;
                    end else begin
                        o_cmd.scan_clr = 1'b1;
                        o_cmd.set_fell = (i_sts.mode == MODE_LATENCY) && i_sts.cc0_lt_warm;
                    end
                end
            end
            S_LL:     o_cmd.ll_step = 1'b1;
            S_LL_END: o_cmd.take_best = 1'b1;
            S_ML_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = DIV_AVG;
            end
            S_ML_WAIT: o_cmd.lat_step = i_sts.div_done;
            S_ML_END:  o_cmd.take_best = 1'b1;
            S_OVL: begin
                o_cmd.addr_sel = ADDR_CHOSEN;
                o_cmd.scan_clr = i_sts.overloaded;
                o_cmd.set_fell = i_sts.overloaded;
            end
            S_PER_WAIT: begin
                o_cmd.pcnt_inc = i_sts.div_done;
                o_cmd.scan_clr = i_sts.div_done && i_sts.rem_zero;
            end
            S_RS_AVG: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = DIV_AVG;
            end
            S_RS_AVGW: o_cmd.save_avg = i_sts.div_done;
            S_RS_SC: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_op    = DIV_SCORE;
            end
            S_RS_SCW: o_cmd.score_wr = i_sts.div_done;
            S_RS_TOT: o_cmd.total_wr = 1'b1;
            S_PTR: begin
                o_cmd.walk_init = 1'b1;
                o_cmd.ptr_load  = i_sts.total_zero;
                o_cmd.div_start = !i_sts.total_zero;
                o_cmd.div_op    = DIV_PTR;
            end
            S_PTR_WAIT: o_cmd.ptr_load = i_sts.div_done;
            S_WALK:     o_cmd.walk_step = 1'b1;
            S_POOL: begin
                o_cmd.addr_sel = ADDR_CHOSEN;
                o_cmd.pool     = 1'b1;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

endmodule

/* hdl/laes_dp.sv */
// Datapath of the endpoint selector: configuration, per-endpoint state, scan and divider.
// Depends on laes_pkg and laes_div; driven by laes_ctrl through t_dp_cmd.
module laes_dp import laes_pkg::*; #(
    parameter int MAX_EPS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic [1:0]  i_req_type,
    input  logic [1:0]  i_endpoint_index,
    input  logic [15:0] i_latency_ms,
    input  logic [30:0] i_random_value,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic [1:0]  o_chosen_endpoint,
    output logic        o_status,
    output logic        o_fell_back
);

    localparam int AW = (MAX_EPS > 1) ? $clog2(MAX_EPS) : 1;
    localparam int CW = $clog2(MAX_EPS + 1);
    // The chosen register also carries the echoed 2-bit index of non-pick events.
    localparam int OW = (AW > 2) ? AW : 2;

    // Configuration registers.
    logic [2:0]  r_ec;
    logic [1:0]  r_mode;
    logic [31:0] r_warm;
    logic [10:0] r_ovl;
    logic [10:0] r_cap;
    logic [15:0] r_per;

    // Per-endpoint state.
    logic [10:0] r_oc    [MAX_EPS];
    logic [39:0] r_lsum  [MAX_EPS];
    logic [31:0] r_ccnt  [MAX_EPS];
    logic [19:0] r_score [MAX_EPS];
    logic [22:0] r_total;
    logic [15:0] r_pcnt;

    // Captured request and working registers.
    logic [1:0]       r_type;
    logic [1:0]       r_idx;
    logic [15:0]      r_lat;
    logic [30:0]      r_rnd;
    logic [CW-1:0]    r_scan;
    logic [AW-1:0]    r_best;
    logic [DIV_W-1:0] r_bestv;
    logic [OW-1:0]    r_chosen;
    logic             r_status;
    logic             r_fell;
    logic [DIV_W-1:0] r_avg;
    logic [22:0]      r_acc;
    logic [22:0]      r_ptr;

    logic [CW-1:0]    w_n;
    logic [CW-1:0]    w_scan_inc;
    logic [AW-1:0]    w_a;
    logic             w_idx_ok;
    logic [10:0]      w_oc;
    logic [39:0]      w_lsum;
    logic [31:0]      w_ccnt;
    logic [19:0]      w_score;
    logic [40:0]      w_lsum_add;
    logic [23:0]      w_acc_add;
    logic [DIV_W-1:0] w_dvd;
    logic [DIV_W-1:0] w_dvs;
    logic             w_div_done;
    logic [DIV_W-1:0] w_quot;
    logic [DIV_W-1:0] w_rem;

    always_comb begin
        if (r_ec == 3'd0) begin
            w_n = CW'(1);
        end else if (32'(r_ec) > 32'(MAX_EPS)) begin
            w_n = CW'(MAX_EPS);
        end else begin
            w_n = CW'(r_ec);
        end
    end

    assign w_scan_inc = CW'(r_scan + 1'b1);
    assign w_idx_ok   = 32'(r_idx) < 32'(MAX_EPS);

    always_comb begin
        case (i_cmd.addr_sel)
            ADDR_SCAN:   w_a = r_scan[AW-1:0];
            ADDR_IDX:    w_a = AW'(r_idx);
            ADDR_CHOSEN: w_a = AW'(r_chosen);
            default:     w_a = r_scan[AW-1:0];
        endcase
    end

    assign w_oc       = r_oc[w_a];
    assign w_lsum     = r_lsum[w_a];
    assign w_ccnt     = r_ccnt[w_a];
    assign w_score    = r_score[w_a];
    assign w_lsum_add = {1'b0, w_lsum} + 41'(r_lat);
    assign w_acc_add  = {1'b0, r_acc} + 24'(w_quot[19:0]);

    always_comb begin
        case (i_cmd.div_op)
            DIV_AVG: begin
                w_dvd = w_lsum;
                w_dvs = (w_ccnt == '0) ? DIV_W'(1) : DIV_W'(w_ccnt);
            end
            DIV_SCORE: begin
                w_dvd = SCORE_SCALE;
                w_dvs = (r_avg == '0) ? DIV_W'(1) : r_avg;
            end
            DIV_PTR: begin
                w_dvd = DIV_W'(r_rnd);
                w_dvs = DIV_W'(r_total);
            end
            DIV_PER: begin
                w_dvd = DIV_W'(r_pcnt);
                w_dvs = (r_per == '0) ? DIV_W'(1) : DIV_W'(r_per);
            end
            default: begin
                w_dvd = w_lsum;
                w_dvs = DIV_W'(1);
            end
        endcase
    end

    laes_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // Configuration writes; writes to indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ec   <= RST_ENDPOINT_COUNT;
            r_mode <= RST_PICK_MODE;
            r_warm <= RST_WARMUP;
            r_ovl  <= RST_OVERLOAD;
            r_cap  <= RST_POOL_CAP;
            r_per  <= RST_RESCORE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ENDPOINT_COUNT: r_ec   <= i_cfg_data[2:0];
                REG_PICK_MODE:      r_mode <= i_cfg_data[1:0];
                REG_WARMUP:         r_warm <= i_cfg_data;
                REG_OVERLOAD:       r_ovl  <= i_cfg_data[10:0];
                REG_POOL_CAP:       r_cap  <= i_cfg_data[10:0];
                REG_RESCORE:        r_per  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Endpoint state with its architectural reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_EPS; i++) begin
                r_oc[i]    <= '0;
                r_lsum[i]  <= 40'd1;
                r_ccnt[i]  <= 32'd1;
                r_score[i] <= '0;
            end
            r_total <= '0;
            r_pcnt  <= '0;
        end else begin
            if (i_cmd.compl && w_idx_ok) begin
                r_lsum[w_a] <= w_lsum_add[40] ? '1 : w_lsum_add[39:0];
                if (w_ccnt != '1) r_ccnt[w_a] <= w_ccnt + 1'b1;
            end
            if (i_cmd.release_conn && w_idx_ok && (w_oc != '0)) begin
                r_oc[w_a] <= w_oc - 1'b1;
            end
            if (i_cmd.pool && (w_oc < r_cap)) begin
                r_oc[w_a] <= w_oc + 1'b1;
            end
            if (i_cmd.score_wr) begin
                r_score[w_a] <= w_quot[19:0];
            end
            if (i_cmd.total_wr) begin
                r_total <= r_acc;
            end
            if (i_cmd.pcnt_inc) begin
                r_pcnt <= r_pcnt + 1'b1;
            end
        end
    end

    // Working registers; the scan counter is the only one that needs a reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else if (i_cmd.scan_clr || i_cmd.walk_init) begin
            r_scan <= '0;
        end else if (i_cmd.ll_step || i_cmd.lat_step || i_cmd.score_wr
                     || (i_cmd.walk_step && !o_sts.walk_hit)) begin
            r_scan <= w_scan_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_type   <= i_req_type;
            r_idx    <= i_endpoint_index;
            r_lat    <= i_latency_ms;
            r_rnd    <= i_random_value;
            r_chosen <= OW'(i_endpoint_index);
            r_status <= 1'b0;
            r_fell   <= 1'b0;
        end
        if (i_cmd.scan_clr) begin
            r_best  <= '0;
            r_bestv <= '1;
            r_acc   <= '0;
        end
        if (i_cmd.ll_step && (DIV_W'(w_oc) < r_bestv)) begin
            r_best  <= w_a;
            r_bestv <= DIV_W'(w_oc);
        end
        if (i_cmd.lat_step && (w_quot < r_bestv)) begin
            r_best  <= w_a;
            r_bestv <= w_quot;
        end
        if (i_cmd.save_avg) begin
            r_avg <= w_quot;
        end
        if (i_cmd.score_wr) begin
            r_acc <= w_acc_add[23] ? TOTAL_MAX : w_acc_add[22:0];
        end
        if (i_cmd.walk_init) begin
            r_chosen <= '0;
        end
        if (i_cmd.ptr_load) begin
            r_ptr <= (r_total == '0) ? '0 : w_rem[22:0];
        end
        if (i_cmd.walk_step) begin
            if (o_sts.walk_hit) begin
                r_chosen <= OW'(w_a);
            end else begin
                r_ptr <= r_ptr - 23'(w_score);
            end
        end
        if (i_cmd.take_best) begin
            r_chosen <= OW'(r_best);
        end
        if (i_cmd.set_fell) begin
            r_fell <= 1'b1;
        end
        if (i_cmd.pool) begin
            r_status <= (w_oc >= r_cap);
        end
    end

    always_comb begin
        o_sts.req_type    = r_type;
        o_sts.mode        = r_mode;
        o_sts.cc0_lt_warm = r_ccnt[0] < r_warm;
        o_sts.overloaded  = w_oc >= r_ovl;
        o_sts.scan_last   = w_scan_inc >= w_n;
        o_sts.div_done    = w_div_done;
        o_sts.rem_zero    = (w_rem == '0);
        o_sts.walk_hit    = r_ptr < 23'(w_score);
        o_sts.total_zero  = (r_total == '0);
    end

    assign o_chosen_endpoint = 2'(r_chosen);
    assign o_status          = r_status;
    assign o_fell_back       = r_fell;

endmodule

/* hdl/latency_aware_endpoint_selector.sv */
// Latency aware endpoint selector, top level. Depends on laes_pkg, laes_ctrl, laes_dp.
// Completion, release and unused request types need no scan; least loaded scans the n endpoints in use,
// and weighted picks and minimum latency picks past warm-up use the shared radix-2 divider (40 quotient
// bits); a weighted pick may also rescore, and an overload fallback adds a least loaded scan.
// One item at a time: the next transfer is accepted in the cycle after the result strobe.
// Reset is synchronous and active low; results have one-cycle strobes and cannot be stalled.
module latency_aware_endpoint_selector import laes_pkg::*; #(
    parameter int MAX_EPS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command channel: a transfer happens when start is high and busy is low.
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_req_type,
    input  logic [1:0]  i_endpoint_index,
    input  logic [15:0] i_latency_ms,
    input  logic [30:0] i_random_value,
    // Result: valid for exactly the cycle in which o_done is high.
    output logic        o_done,
    output logic [1:0]  o_chosen_endpoint,
    output logic        o_status,
    output logic        o_fell_back,
    // Configuration write channel, always ready; software must write it only when idle (unenforced).
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // The controller sequences scans over the endpoints and the divisions; the
    // datapath holds all other state and reports back through a small status struct.
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    laes_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    laes_dp #(
        .MAX_EPS (MAX_EPS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_req_type        (i_req_type),
        .i_endpoint_index  (i_endpoint_index),
        .i_latency_ms      (i_latency_ms),
        .i_random_value    (i_random_value),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_chosen_endpoint (o_chosen_endpoint),
        .o_status          (o_status),
        .o_fell_back       (o_fell_back)
    );

endmodule
